// ===== design/tdmc_pkg.sv =====
// Package for the tuning dial motor controller.
// Holds state codes, command codes, relay bit positions and the default limit.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tdmc_pkg;

  localparam int unsigned StateW   = 3;
  localparam int unsigned CmdW     = 4;
  localparam int unsigned TimeW    = 16;
  localparam int unsigned RelayW   = 3;

  // Dial states
  localparam logic [StateW-1:0] ST_WAIT        = 3'd0;
  localparam logic [StateW-1:0] ST_SLOW_LEFT   = 3'd1;
  localparam logic [StateW-1:0] ST_SLOW_RIGHT  = 3'd2;
  localparam logic [StateW-1:0] ST_FAST_LEFT   = 3'd3;
  localparam logic [StateW-1:0] ST_FAST_RIGHT  = 3'd4;
  localparam logic [StateW-1:0] ST_LEAVE_LEFT  = 3'd5;
  localparam logic [StateW-1:0] ST_LEAVE_RIGHT = 3'd6;
  localparam logic [StateW-1:0] ST_ACTIVE      = 3'd7;

  // Remote commands
  localparam logic [CmdW-1:0] CMD_FASTLEFT    = 4'd0;
  localparam logic [CmdW-1:0] CMD_FASTRIGHT   = 4'd1;
  localparam logic [CmdW-1:0] CMD_LEFT        = 4'd2;
  localparam logic [CmdW-1:0] CMD_RIGHT       = 4'd3;
  localparam logic [CmdW-1:0] CMD_SEARCHLEFT  = 4'd4;
  localparam logic [CmdW-1:0] CMD_SEARCHRIGHT = 4'd5;
  localparam logic [CmdW-1:0] CMD_INACTIVE    = 4'd6;
  localparam logic [CmdW-1:0] CMD_ACTIVE      = 4'd7;
  localparam logic [CmdW-1:0] CMD_STOP        = 4'd8;

  // Request kinds
  localparam logic REQ_COMMAND = 1'b0;
  localparam logic REQ_TIMER   = 1'b1;

  // Relay pattern: bit 0 left, bit 1 right, bit 2 fast
  typedef struct packed {
    logic fast;
    logic right;
    logic left;
  } relay_t;

  localparam relay_t RELAYS_OFF = '{fast: 1'b0, right: 1'b0, left: 1'b0};

  localparam logic [TimeW-1:0] DEFAULT_LIMIT_MS = 16'd30000;

  // Relay pattern set on entering a move or search-leave state.
  function automatic relay_t relays_for_state(input logic [StateW-1:0] st);
    relay_t r;
    r = RELAYS_OFF;
    unique case (st)
      ST_SLOW_LEFT:   r.left = 1'b1;
      ST_SLOW_RIGHT:  r.right = 1'b1;
      ST_FAST_LEFT:   begin
        r.left = 1'b1;
        r.fast = 1'b1;
      end
      ST_FAST_RIGHT:  begin
        r.right = 1'b1;
        r.fast  = 1'b1;
      end
      ST_LEAVE_LEFT:  r.left = 1'b1;
      ST_LEAVE_RIGHT: r.right = 1'b1;
      default:        r = RELAYS_OFF;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== design/tuning_dial_motor_controller.sv =====
// Tuning dial motor controller: eight-state dial FSM with relay outputs.
// Depends on tdmc_pkg for state and command codes and relay patterns.
// Output: a result is registered and appears in the cycle after its transaction is accepted.
// Throughput: one transaction per cycle while the result sink does not stall; the single FSM update and the
// 16-bit clamp compare fit between the state registers and the result register.
// Reset: asynchronous, active low; dial goes to wait, relays off,
// movement limit back to 30000 ms, result register empty.
`timescale 1ns / 1ps
`default_nettype none

module tuning_dial_motor_controller (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  // configuration
  input  wire                          cfg_we_i,
  input  wire [tdmc_pkg::TimeW-1:0]    cfg_wdata_i,
  // request channel
  input  wire                          in_valid_i,
  output logic                         in_stall_o,
  input  wire                          req_type_i,
  input  wire [tdmc_pkg::CmdW-1:0]     command_i,
  input  wire [tdmc_pkg::TimeW-1:0]    request_time_ms_i,
  // result channel
  output logic                         out_valid_o,
  input  wire                          out_stall_i,
  output logic                         relay_left_o,
  output logic                         relay_right_o,
  output logic                         relay_fast_o,
  output logic [tdmc_pkg::StateW-1:0]  state_code_o,
  output logic [tdmc_pkg::TimeW-1:0]   timeout_ms_o,
  output logic                         timeout_valid_o
);

  import tdmc_pkg::*;

  logic [TimeW-1:0]  limit_q;
  logic [StateW-1:0] state_q, state_d;
  relay_t            relay_q, relay_d;

  logic              out_valid_q;
  relay_t            out_relay_q;
  logic [StateW-1:0] out_state_q;
  logic [TimeW-1:0]  out_timeout_q, timeout_d;
  logic              out_tvalid_q;

  logic              in_accept;
  logic              out_accept;
  logic [TimeW-1:0]  req_clamped;
  logic              use_time;

  // Stall input only while a finished result waits and the sink stalls.
  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_accept  = in_valid_i & ~in_stall_o;
  assign out_accept = out_valid_q & ~out_stall_i;

  // Clamp the requested time to the movement limit.
  assign req_clamped = (request_time_ms_i > limit_q) ? limit_q : request_time_ms_i;

  // Next state, relays and timeout for one transaction.
  always_comb begin
    state_d  = state_q;
    relay_d  = relay_q;
    use_time = 1'b0;

    if (req_type_i == REQ_TIMER) begin
      // timer expiry stops the dial from any state
      state_d = ST_WAIT;
      relay_d = RELAYS_OFF;
    end else if (command_i == CMD_STOP) begin
      state_d = ST_WAIT;
      relay_d = RELAYS_OFF;
    end else begin
      unique case (state_q) inside
        ST_WAIT: begin
          unique case (command_i)
            CMD_FASTLEFT:    begin state_d = ST_FAST_LEFT;   use_time = 1'b1; end
            CMD_FASTRIGHT:   begin state_d = ST_FAST_RIGHT;  use_time = 1'b1; end
            CMD_LEFT:        begin state_d = ST_SLOW_LEFT;   use_time = 1'b1; end
            CMD_RIGHT:       begin state_d = ST_SLOW_RIGHT;  use_time = 1'b1; end
            CMD_SEARCHLEFT:  begin state_d = ST_LEAVE_LEFT;  use_time = 1'b1; end
            CMD_SEARCHRIGHT: begin state_d = ST_LEAVE_RIGHT; use_time = 1'b1; end
            default:         state_d = state_q;
          endcase
          if (use_time) begin
            relay_d = relays_for_state(state_d);
          end
        end
        ST_SLOW_LEFT, ST_SLOW_RIGHT, ST_FAST_LEFT, ST_FAST_RIGHT: begin
          // a running move may turn into a search
          if (command_i == CMD_SEARCHLEFT) begin
            state_d  = ST_LEAVE_LEFT;
            relay_d  = relays_for_state(ST_LEAVE_LEFT);
            use_time = 1'b1;
          end else if (command_i == CMD_SEARCHRIGHT) begin
            state_d  = ST_LEAVE_RIGHT;
            relay_d  = relays_for_state(ST_LEAVE_RIGHT);
            use_time = 1'b1;
          end
        end
        ST_LEAVE_LEFT, ST_LEAVE_RIGHT: begin
          // station left behind: keep the leave relays, report full limit
          if (command_i == CMD_INACTIVE) begin
            state_d = ST_ACTIVE;
          end
        end
        ST_ACTIVE: begin
          // station found: stop the dial
          if (command_i == CMD_ACTIVE) begin
            state_d = ST_WAIT;
            relay_d = RELAYS_OFF;
          end
        end
        default: begin
          state_d = state_q;
        end
      endcase
    end

    if (req_type_i == REQ_TIMER) begin
      timeout_d = '0;
    end else if (use_time) begin
      timeout_d = req_clamped;
    end else begin
      timeout_d = limit_q;
    end
  end

  // Movement limit register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= DEFAULT_LIMIT_MS;
    end else if (cfg_we_i) begin
      limit_q <= cfg_wdata_i;
    end
  end

  // Dial state and relays advance on each accepted transaction.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_WAIT;
      relay_q <= RELAYS_OFF;
    end else if (in_accept) begin
      state_q <= state_d;
      relay_q <= relay_d;
    end
  end

  // Result register valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_accept) begin
      out_valid_q <= 1'b1;
    end else if (out_accept) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload; hold while stalled.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      out_relay_q   <= relay_d;
      out_state_q   <= state_d;
      out_timeout_q <= timeout_d;
      out_tvalid_q  <= (req_type_i == REQ_COMMAND);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign relay_left_o    = out_relay_q.left;
  assign relay_right_o   = out_relay_q.right;
  assign relay_fast_o    = out_relay_q.fast;
  assign state_code_o    = out_state_q;
  assign timeout_ms_o    = out_timeout_q;
  assign timeout_valid_o = out_tvalid_q;

  // The dial never drives left and right together.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(relay_q.left && relay_q.right))
    else $error("left and right relays both on");

  // Wait state always has all relays off.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WAIT) |-> (relay_q == RELAYS_OFF))
    else $error("relays on in wait state");

  // A timer transaction stops the dial and yields a zero, invalid timeout.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && req_type_i == REQ_TIMER) |=>
      (state_q == ST_WAIT && out_valid_q && !out_tvalid_q && out_timeout_q == '0))
    else $error("timer transaction did not stop the dial");

  // Result register mirrors the live state after each accepted transaction.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (out_state_q == state_q && out_relay_q == relay_q))
    else $error("result register out of step with dial state");

endmodule

`default_nettype wire
